/* rtl/qbp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qbp_pkg: shared types and constants for the quantizing bit packer
// Field widths, payload structs and register indexes used by all modules.
// ----------------------------------------------------------------------------
package qbp_pkg;

  localparam int MAX_CODE_WIDTH = 32;
  localparam int CW_W           = $clog2(MAX_CODE_WIDTH + 1);
  localparam int ACC_W          = MAX_CODE_WIDTH + 7;
  localparam int CNT_W          = $clog2(ACC_W + 1);

  localparam int SAMPLE_W = 32;
  localparam int FS_W     = 31;
  localparam int CWREG_W  = 6;
  localparam int CFG_W    = 31;
  localparam int IDX_W    = 1;

  localparam logic [IDX_W-1:0] REG_FULL_SCALE = 1'd0;
  localparam logic [IDX_W-1:0] REG_CODE_WIDTH = 1'd1;

  localparam logic [FS_W-1:0]    FULL_SCALE_RST = 31'd65536;
  localparam logic [CWREG_W-1:0] CODE_WIDTH_RST = 6'd27;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_block;
  } item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       final_byte;
  } result_t;

  // one quantized code on its way from the divider to the packer
  typedef struct packed {
    logic [MAX_CODE_WIDTH-1:0] code;
    logic [CW_W-1:0]           width;
    logic                      last;
  } code_t;

endpackage

`default_nettype wire

/* rtl/qbp_quant.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qbp_quant: sample classifier and quantizer
// Accepts one sample, sorts out the clipped cases and runs a restoring
// division for the rest, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qbp_quant import qbp_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire item_t           item,
  input  wire logic [FS_W-1:0] full_scale,
  input  wire logic [CW_W-1:0] width,
  output logic                 code_push,
  input  wire logic            code_full,
  output code_t                code_out
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIX, ST_DONE} state_t;

  state_t                    state;
  logic [FS_W-1:0]           rem;
  logic [FS_W-1:0]           num;
  logic [MAX_CODE_WIDTH-1:0] quo;
  logic [CW_W-1:0]           step;
  logic [CW_W-1:0]           wid;
  logic                      last;

  logic [SAMPLE_W-1:0]       raw;
  logic [FS_W:0]             rem_sh;
  logic                      sub_ok;
  logic [FS_W:0]             rem_sub;
  logic [MAX_CODE_WIDTH-1:0] max_code;

  assign raw      = item.sample;
  assign rem_sh   = {rem, 1'b0};
  assign sub_ok   = rem_sh >= {1'b0, full_scale};
  assign rem_sub  = rem_sh - {1'b0, full_scale};
  assign max_code = {MAX_CODE_WIDTH{1'b1}} >> (CW_W'(MAX_CODE_WIDTH) - width);

  assign full      = state != ST_IDLE;
  assign code_push = (state == ST_DONE) && !code_full;
  assign code_out  = '{code: quo, width: wid, last: last};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (push) begin
            wid  <= width;
            last <= item.end_of_block;
            if (raw == '0 || raw[SAMPLE_W-1]) begin
              quo   <= MAX_CODE_WIDTH'(1);
              state <= ST_DONE;
            end else if (raw[FS_W-1:0] >= full_scale) begin
              quo   <= max_code;
              state <= ST_DONE;
            end else begin
              rem   <= raw[FS_W-1:0];
              num   <= raw[FS_W-1:0];
              quo   <= '0;
              step  <= '0;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (sub_ok) begin
            rem <= rem_sub[FS_W-1:0];
          end else begin
            rem <= rem_sh[FS_W-1:0];
          end
          quo  <= {quo[MAX_CODE_WIDTH-2:0], sub_ok};
          step <= step + CW_W'(1);
          if (step == wid - CW_W'(1)) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          // quotient is floor(s*2^w/f); drop by one when rem < s to get floor(s*(2^w-1)/f)
          if (rem < num) begin
            quo <= quo - MAX_CODE_WIDTH'(1);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!code_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> step < wid)
    else $error("division step past code width");

  a_push_done: assert property (@(posedge clk) disable iff (rst)
    code_push |-> state == ST_DONE)
    else $error("code beat outside done state");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIX |-> rem < full_scale)
    else $error("remainder not below full scale");

endmodule

`default_nettype wire

/* rtl/qbp_code_q.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qbp_code_q: two-entry code queue
// Decouples the quantizer from the packer so either side can stall.
// ----------------------------------------------------------------------------
module qbp_code_q import qbp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire code_t din,
  output logic       full,
  input  wire logic  pop,
  output code_t      dout,
  output logic       empty
);

  code_t       mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("code queue over capacity");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("code queue pointers disagree with count");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count == 2'd1 |-> wr_ptr != rd_ptr)
    else $error("code queue pointers disagree with count");

endmodule

`default_nettype wire

/* rtl/qbp_pack.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qbp_pack: LSB-first bit packer with result queue
// Appends each code above the leftover bits, emits complete bytes, pads and
// marks the last byte of a block.
// ----------------------------------------------------------------------------
module qbp_pack import qbp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire code_t code_in,
  input  wire logic  code_empty,
  output logic       code_pop,
  output result_t    result,
  output logic       empty,
  input  wire logic  pop
);

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t           state;
  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic             last;

  result_t          oq [2];
  logic             oq_wr;
  logic             oq_rd;
  logic [1:0]       oq_cnt;
  logic             oq_full;

  logic             have_byte;
  logic             emit;
  logic             do_pop;
  result_t          beat;

  assign have_byte = (cnt >= CNT_W'(8)) || (last && cnt != '0);
  assign oq_full   = oq_cnt == 2'd2;
  assign emit      = (state == ST_EMIT) && have_byte && !oq_full;
  assign code_pop  = (state == ST_IDLE) && !code_empty;
  assign beat      = '{packed_byte: acc[7:0], final_byte: last && cnt <= CNT_W'(8)};
  assign empty     = oq_cnt == 2'd0;
  assign do_pop    = pop && !empty;
  assign result    = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      acc   <= '0;
      cnt   <= '0;
      last  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!code_empty) begin
            acc   <= acc | (ACC_W'(code_in.code) << cnt[2:0]);
            cnt   <= cnt + CNT_W'(code_in.width);
            last  <= code_in.last;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!have_byte) begin
            last  <= 1'b0;
            state <= ST_IDLE;
          end else if (!oq_full) begin
            // advance one byte; a padded final byte empties the packer
            acc <= acc >> 8;
            cnt <= (cnt >= CNT_W'(8)) ? cnt - CNT_W'(8) : '0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq[oq_wr] <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr  <= 1'b0;
      oq_rd  <= 1'b0;
      oq_cnt <= 2'd0;
    end else begin
      if (emit)   oq_wr <= ~oq_wr;
      if (do_pop) oq_rd <= ~oq_rd;
      oq_cnt <= oq_cnt + {1'b0, emit} - {1'b0, do_pop};
    end
  end

  a_idle_leftover: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> cnt < CNT_W'(8))
    else $error("packer idle with a complete byte held");

  a_oq_bound: assert property (@(posedge clk) disable iff (rst) oq_cnt <= 2'd2)
    else $error("result queue over capacity");

  a_final_empties: assert property (@(posedge clk) disable iff (rst)
    emit && beat.final_byte |=> cnt == '0)
    else $error("bits left after final byte");

  a_block_clean: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> acc[ACC_W-1:7] == '0)
    else $error("stale bits above leftover");

endmodule

`default_nettype wire

/* rtl/quantize_bit_packer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// quantize_bit_packer: Q16.16 sample quantizer and LSB-first byte packer
// Quantizes each sample to a code of configurable width against a
// configured full scale and packs the codes into a byte stream.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  -------   ---------------  -----------------------------------
//  item      push / full      item.sample, item.end_of_block
//  result    pop / empty      result.packed_byte, result.final_byte
//  config    cfg_we           cfg_index, cfg_data
//
//  A sample that needs division steps through idle, div, fix and done, one
//  quotient bit a cycle in div; clipped samples skip to done. The packer
//  emits up to five bytes, one a cycle while the result queue has room,
//  behind a two-entry code queue, so its work overlaps the next division.
//  Reset is synchronous: both queues and the leftover bits are cleared and
//  the registers return to full scale 65536 and width 27.
//  full rises while a sample is in the quantizer; a stalled result side
//  backs up through the queues to full.
// ----------------------------------------------------------------------------
module quantize_bit_packer import qbp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire item_t            item,
  output logic                  empty,
  input  wire logic             pop,
  output result_t               result,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  logic [FS_W-1:0]    full_scale;
  logic [CWREG_W-1:0] code_width;
  logic [CW_W-1:0]    eff_width;

  logic  code_push;
  logic  code_full;
  logic  code_pop;
  logic  code_empty;
  code_t code_in;
  code_t code_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FULL_SCALE_RST;
      code_width <= CODE_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FULL_SCALE: full_scale <= cfg_data[FS_W-1:0];
        REG_CODE_WIDTH: code_width <= cfg_data[CWREG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero width counts as one; clamp to the widest supported code
  always_comb begin
    if (code_width == '0) begin
      eff_width = CW_W'(1);
    end else if (int'(code_width) > MAX_CODE_WIDTH) begin
      eff_width = CW_W'(MAX_CODE_WIDTH);
    end else begin
      eff_width = CW_W'(code_width);
    end
  end

  qbp_quant u_quant (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .full_scale (full_scale),
    .width      (eff_width),
    .code_push  (code_push),
    .code_full  (code_full),
    .code_out   (code_in)
  );

  qbp_code_q u_code_q (
    .clk   (clk),
    .rst   (rst),
    .push  (code_push),
    .din   (code_in),
    .full  (code_full),
    .pop   (code_pop),
    .dout  (code_out),
    .empty (code_empty)
  );

  qbp_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .code_in    (code_out),
    .code_empty (code_empty),
    .code_pop   (code_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

`default_nettype wire
